@@ rtl/cblt_pkg.sv @@
// ----------------------------------------------------------------------------
// cblt_pkg
// Shared types and fixed constants of the cubic Bezier loop tessellator.
// ----------------------------------------------------------------------------
package cblt_pkg;

	// Points per segment and channels per point
	localparam int NUM_PTS    = 4;
	localparam int NUM_CH     = 4;

	// Bernstein weight: unsigned Q0.16 held in 17 bits so 1.0 is exact
	localparam int WGT_W      = 17;
	localparam longint WGT_ONE = 64'd65536;
	localparam int FRAC_SH    = 16;
	localparam int ROUND_HALF = 32768;

	// Sample index port width (SAMPLES tops out at 64)
	localparam int IDX_W      = 6;

	// Segment queue depth between front and back
	localparam int QDEPTH     = 2;

	// Position inside the current segment once the start point is taken
	typedef enum logic [1:0] {
		PH_HANDLE1,
		PH_HANDLE2,
		PH_END
	} phase_t;

endpackage

@@ rtl/cblt_front.sv @@
// ----------------------------------------------------------------------------
// cblt_front
// Takes control points, tracks segment position and emits full segments.
// ----------------------------------------------------------------------------
module cblt_front #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pt_valid,
	output logic                                pt_stall,
	input  logic [cblt_pkg::NUM_CH*COORD_WIDTH-1:0] point,
	input  logic                                close_loop,
	input  logic                                q_full,
	output logic                                push,
	output logic [cblt_pkg::NUM_PTS*cblt_pkg::NUM_CH*COORD_WIDTH-1:0] job
);
	import cblt_pkg::*;

	localparam int PT_W = NUM_CH * COORD_WIDTH;

	phase_t           phase_q, phase_d;
	logic             started_q, started_d;
	logic [PT_W-1:0]  start_q;
	logic [PT_W-1:0]  held_q [3];
	logic             accept;

	assign pt_stall = q_full;
	assign accept   = pt_valid && !q_full;

	// next state
	always_comb begin
		phase_d   = phase_q;
		started_d = started_q;
		if (accept) begin
			if (!started_q) begin
				phase_d   = PH_HANDLE1;
				started_d = 1'b1;
			end else begin
				case (phase_q)
					PH_HANDLE1: phase_d = PH_HANDLE2;
					PH_HANDLE2: begin
						if (close_loop) begin
							phase_d   = PH_HANDLE1;
							started_d = 1'b0;
						end else begin
							phase_d = PH_END;
						end
					end
					PH_END:     phase_d = PH_HANDLE1;
					default:    phase_d = PH_HANDLE1;
				endcase
			end
		end
	end

	// outputs: segment push and its four points, P0 in the low bits
	always_comb begin
		push = 1'b0;
		job  = {point, held_q[2], held_q[1], held_q[0]};
		case (phase_q)
			PH_HANDLE2: begin
				push = accept && started_q && close_loop;
				job  = {start_q, point, held_q[1], held_q[0]};
			end
			PH_END: begin
				push = accept && started_q;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HANDLE1;
			started_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			started_q <= started_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!started_q) begin
				start_q   <= point;
				held_q[0] <= point;
			end else begin
				case (phase_q)
					PH_HANDLE1: held_q[1] <= point;
					PH_HANDLE2: held_q[2] <= point;
					PH_END:     held_q[0] <= point;
					default:    held_q[0] <= held_q[0];
				endcase
			end
		end
	end

endmodule

@@ rtl/cblt_queue.sv @@
// ----------------------------------------------------------------------------
// cblt_queue
// Small segment queue that decouples the front from the sample engine.
// ----------------------------------------------------------------------------
module cblt_queue #(
	parameter int WIDTH = 256,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             not_empty,
	output logic             full,
	output logic [WIDTH-1:0] head
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)      count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

@@ rtl/cblt_back.sv @@
// ----------------------------------------------------------------------------
// cblt_back
// Sample engine: walks t = k/SAMPLES over the head segment, three stages.
// ----------------------------------------------------------------------------
module cblt_back #(
	parameter int SAMPLES     = 10,
	parameter int COORD_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_ready,
	input  logic [cblt_pkg::NUM_PTS*cblt_pkg::NUM_CH*COORD_WIDTH-1:0] job,
	output logic job_pop,
	output logic smp_valid,
	input  logic smp_stall,
	output logic [cblt_pkg::NUM_CH*COORD_WIDTH-1:0] smp_point,
	output logic [cblt_pkg::IDX_W-1:0] sample_index,
	output logic segment_last
);
	import cblt_pkg::*;

	localparam int KW = $clog2(SAMPLES);
	localparam int PW = COORD_WIDTH + WGT_W + 1;   // product
	localparam int AW = COORD_WIDTH + 21;          // accumulator
	localparam int RW = AW - FRAC_SH;              // after rounding shift
	localparam longint Den = longint'(SAMPLES) * SAMPLES * SAMPLES;

	// Bernstein weight table, one row per sample
	logic [WGT_W-1:0] wtab [SAMPLES][NUM_PTS];

	for (genvar k = 0; k < SAMPLES; k++) begin : g_wtab
		localparam longint A  = longint'(SAMPLES - k);
		localparam longint B  = longint'(k);
		localparam longint W0 = (A * A * A * WGT_ONE + Den / 2) / Den;
		localparam longint W1 = (3 * A * A * B * WGT_ONE + Den / 2) / Den;
		localparam longint W2 = (3 * A * B * B * WGT_ONE + Den / 2) / Den;
		localparam longint W3 = (B * B * B * WGT_ONE + Den / 2) / Den;
		assign wtab[k][0] = WGT_W'(W0);
		assign wtab[k][1] = WGT_W'(W1);
		assign wtab[k][2] = WGT_W'(W2);
		assign wtab[k][3] = WGT_W'(W3);
	end

	logic                    adv, issue, k_last;
	logic [KW-1:0]           k_q;
	logic                    valid_s1, valid_s2, valid_s3;
	logic [KW-1:0]           k_s1, k_s2, k_s3;
	logic                    last_s1, last_s2, last_s3;
	logic signed [PW-1:0]    prod_d  [NUM_CH][NUM_PTS];
	logic signed [PW-1:0]    prod_s1 [NUM_CH][NUM_PTS];
	logic signed [AW-1:0]    suma_s2 [NUM_CH];
	logic signed [AW-1:0]    sumb_s2 [NUM_CH];
	logic signed [AW-1:0]    acc     [NUM_CH];
	logic signed [RW-1:0]    rnd     [NUM_CH];
	logic [COORD_WIDTH-1:0]  sat     [NUM_CH];
	logic [COORD_WIDTH-1:0]  out_s3  [NUM_CH];
	logic [RW-COORD_WIDTH:0] upper   [NUM_CH];

	// whole pipe moves unless a finished sample is held at the output
	assign adv     = !(valid_s3 && smp_stall);
	assign issue   = adv && job_ready;
	assign k_last  = (k_q == KW'(SAMPLES - 1));
	assign job_pop = issue && k_last;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			for (int i = 0; i < NUM_PTS; i++) begin
				prod_d[c][i] = $signed({1'b0, wtab[k_q][i]})
				             * $signed(job[(i*NUM_CH + c)*COORD_WIDTH +: COORD_WIDTH]);
			end
		end
	end

	// final add, round half up, saturate
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			acc[c]   = suma_s2[c] + sumb_s2[c] + AW'(ROUND_HALF);
			rnd[c]   = RW'(acc[c] >>> FRAC_SH);
			upper[c] = rnd[c][RW-1:COORD_WIDTH-1];
			if (&upper[c] || ~|upper[c]) begin
				sat[c] = rnd[c][COORD_WIDTH-1:0];
			end else begin
				sat[c] = {rnd[c][RW-1], {(COORD_WIDTH-1){~rnd[c][RW-1]}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (issue) k_q <= k_last ? '0 : k_q + KW'(1);
			if (adv) begin
				valid_s1 <= issue;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s1    <= k_q;
			last_s1 <= k_last;
			prod_s1 <= prod_d;
			k_s2    <= k_s1;
			last_s2 <= last_s1;
			for (int c = 0; c < NUM_CH; c++) begin
				suma_s2[c] <= AW'(prod_s1[c][0]) + AW'(prod_s1[c][1]);
				sumb_s2[c] <= AW'(prod_s1[c][2]) + AW'(prod_s1[c][3]);
			end
			k_s3    <= k_s2;
			last_s3 <= last_s2;
			out_s3  <= sat;
		end
	end

	assign smp_valid    = valid_s3;
	assign sample_index = IDX_W'(k_s3);
	assign segment_last = last_s3;

	for (genvar c = 0; c < NUM_CH; c++) begin : g_pack
		assign smp_point[c*COORD_WIDTH +: COORD_WIDTH] = out_s3[c];
	end

endmodule

@@ rtl/cubic_bezier_loop_tessellator_unit.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_loop_tessellator_unit
// Streams 4D control points in and cubic Bezier curve samples out.
// ----------------------------------------------------------------------------
// Feed a start endpoint, then groups of handle, handle, endpoint; every
// endpoint also opens the next segment. Each completed segment produces
// SAMPLES results at t = k/SAMPLES, k = 0..SAMPLES-1, with segment_last on
// the final one. Raising close_loop on a second handle finishes that segment
// at the loop's start endpoint and returns the block to expecting a new start
// point; the flag is ignored anywhere else. Coordinates and results are
// signed Q1.14, rounded half up and saturated. Points are taken one per
// cycle while the two-entry segment queue has room; the sample engine emits
// one sample per cycle while smp_stall is low. Each sample is registered
// in the product, sum and output stages once its segment heads the queue.
// ----------------------------------------------------------------------------
module cubic_bezier_loop_tessellator_unit #(
	parameter int SAMPLES     = 10,
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// point request channel
	input  logic                          pt_valid,
	output logic                          pt_stall,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	input  logic signed [COORD_WIDTH-1:0] coord_z,
	input  logic signed [COORD_WIDTH-1:0] coord_w,
	input  logic                          close_loop,
	// sample request channel
	output logic                          smp_valid,
	input  logic                          smp_stall,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic signed [COORD_WIDTH-1:0] out_z,
	output logic signed [COORD_WIDTH-1:0] out_w,
	output logic [cblt_pkg::IDX_W-1:0]    sample_index,
	output logic                          segment_last
);
	import cblt_pkg::*;

	localparam int PT_W  = NUM_CH * COORD_WIDTH;
	localparam int JOB_W = NUM_PTS * PT_W;

	logic [PT_W-1:0]  point, smp_point;
	logic [JOB_W-1:0] push_job, head_job;
	logic             push, q_full, q_not_empty, pop;

	// channel 0 = x in the low bits
	assign point = {coord_w, coord_z, coord_y, coord_x};

	// front: segment bookkeeping
	cblt_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_valid  (pt_valid),
		.pt_stall  (pt_stall),
		.point     (point),
		.close_loop(close_loop),
		.q_full    (q_full),
		.push      (push),
		.job       (push_job)
	);

	// completed segments wait here
	cblt_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_job),
		.pop      (pop),
		.not_empty(q_not_empty),
		.full     (q_full),
		.head     (head_job)
	);

	// back: multiply, two-level sum, round and saturate
	cblt_back #(
		.SAMPLES    (SAMPLES),
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_ready   (q_not_empty),
		.job         (head_job),
		.job_pop     (pop),
		.smp_valid   (smp_valid),
		.smp_stall   (smp_stall),
		.smp_point   (smp_point),
		.sample_index(sample_index),
		.segment_last(segment_last)
	);

	assign out_x = smp_point[0*COORD_WIDTH +: COORD_WIDTH];
	assign out_y = smp_point[1*COORD_WIDTH +: COORD_WIDTH];
	assign out_z = smp_point[2*COORD_WIDTH +: COORD_WIDTH];
	assign out_w = smp_point[3*COORD_WIDTH +: COORD_WIDTH];

endmodule

@@ rtl/cblt_checker.sv @@
// ----------------------------------------------------------------------------
// cblt_checker
// Port-level checks of the tessellator, bound to the top level.
// ----------------------------------------------------------------------------
module cblt_checker #(
	parameter int SAMPLES     = 10,
	parameter int COORD_WIDTH = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pt_stall,
	input logic                          smp_valid,
	input logic                          smp_stall,
	input logic signed [COORD_WIDTH-1:0] out_x,
	input logic signed [COORD_WIDTH-1:0] out_y,
	input logic signed [COORD_WIDTH-1:0] out_z,
	input logic signed [COORD_WIDTH-1:0] out_w,
	input logic [cblt_pkg::IDX_W-1:0]    sample_index,
	input logic                          segment_last
);
	import cblt_pkg::*;

	// reset empties the pipe and the queue
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !smp_valid && !pt_stall)
		else $error("outputs not idle in reset");

	// held sample stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_stall |=> smp_valid && $stable(sample_index)
		&& $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(out_w)
		&& $stable(segment_last))
		else $error("stalled sample changed");

	// last flag marks exactly the final sample
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid |-> (segment_last == (sample_index == IDX_W'(SAMPLES - 1))))
		else $error("segment_last does not match sample_index");

	// samples of one segment follow back to back in order
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && !smp_stall && !segment_last |=>
		smp_valid && sample_index == $past(sample_index) + IDX_W'(1))
		else $error("sample sequence broken");

	// a new segment starts at index zero
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && !smp_stall && segment_last |=>
		!smp_valid || sample_index == '0)
		else $error("segment did not start at index zero");

endmodule

bind cubic_bezier_loop_tessellator_unit cblt_checker #(
	.SAMPLES    (SAMPLES),
	.COORD_WIDTH(COORD_WIDTH)
) u_cblt_checker (.*);

@@ test/cubic_bezier_loop_tessellator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_loop_tessellator_unit_tb
// Self-checking bench for the cubic Bezier loop tessellator. A scoreboard
// tracks the loop and segment state of the block. For every point that the
// block accepts it computes the curve samples due, with the same Q0.16
// Bernstein weights and the same rounding and saturation. Every sample that
// the block hands out is checked against the oldest one still pending.
// Directed loops cover the coordinate extremes and every placement of the
// close flag. Random loops follow, most of them well formed, with random
// idling on both channels, one long sample hold-off and one full drain.
// ----------------------------------------------------------------------------
module cubic_bezier_loop_tessellator_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import cblt_pkg::*;

	localparam int SEG_SAMPLES = 10;
	localparam int COORD_W     = 16;
	localparam int RAND_POINTS = 330;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 40;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef coord_t point_t [NUM_CH];

	// One curve sample as it leaves the block
	typedef struct {
		coord_t               pos [NUM_CH];
		logic [IDX_W-1:0]     idx;
		logic                 last;
	} curve_sample_t;

	localparam coord_t C_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t C_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
	localparam coord_t C_ZERO = '0;

	// ------------------------------------------------------------------------
	// Scoreboard: follows the loop state and queues the samples that are due
	// ------------------------------------------------------------------------
	class bezier_scoreboard;
		point_t          loop_start;
		point_t          held [3];
		phase_t          phase;
		bit              started;
		curve_sample_t   due [$];
		int              errors;

		function new();
			foreach (loop_start[c]) loop_start[c] = '0;
			phase   = PH_HANDLE1;
			started = 1'b0;
			errors  = 0;
		endfunction

		function int pending();
			return due.size();
		endfunction

		// Q0.16 weight num/S^3, rounded half up
		function longint bern_weight(longint num);
			longint den;
			den = longint'(SEG_SAMPLES) * SEG_SAMPLES * SEG_SAMPLES;
			return (num * 65536 + den / 2) / den;
		endfunction

		// Queue SEG_SAMPLES samples of the segment held[0..2] -> p3
		function void tessellate(point_t p3);
			longint        wt [4];
			longint        a, b, acc, r;
			curve_sample_t s;
			for (int k = 0; k < SEG_SAMPLES; k++) begin
				a = SEG_SAMPLES - k;
				b = k;
				wt[0] = bern_weight(a * a * a);
				wt[1] = bern_weight(3 * a * a * b);
				wt[2] = bern_weight(3 * a * b * b);
				wt[3] = bern_weight(b * b * b);
				for (int c = 0; c < NUM_CH; c++) begin
					acc = wt[0] * longint'(held[0][c]) + wt[1] * longint'(held[1][c])
					    + wt[2] * longint'(held[2][c]) + wt[3] * longint'(p3[c]);
					// shift with rounding half toward +inf, then clamp
					r = (acc + 32768) >>> 16;
					if (r > longint'(C_MAX)) r = longint'(C_MAX);
					if (r < longint'(C_MIN)) r = longint'(C_MIN);
					s.pos[c] = coord_t'(r);
				end
				s.idx  = k[IDX_W-1:0];
				s.last = (k == SEG_SAMPLES - 1);
				due.push_back(s);
			end
		endfunction

		// An accepted point request
		function void note_point(point_t p, logic close_flag);
			if (!started) begin
				// close flag on a start point means nothing
				loop_start = p;
				held[0]    = p;
				phase      = PH_HANDLE1;
				started    = 1'b1;
				return;
			end
			case (phase)
				PH_HANDLE1: begin
					held[1] = p;
					phase   = PH_HANDLE2;
				end
				PH_HANDLE2: begin
					held[2] = p;
					if (close_flag) begin
						// loop closes on its first endpoint, then back to reset
						tessellate(loop_start);
						foreach (loop_start[c]) loop_start[c] = '0;
						started = 1'b0;
						phase   = PH_HANDLE1;
					end else begin
						phase = PH_END;
					end
				end
				default: begin
					tessellate(p);
					held[0] = p;
					phase   = PH_HANDLE1;
				end
			endcase
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		// An accepted sample request
		function void check_sample(curve_sample_t got);
			curve_sample_t want;
			if (due.size() == 0) begin
				$error("sample with none pending: x %0d y %0d z %0d w %0d idx %0d",
				       got.pos[0], got.pos[1], got.pos[2], got.pos[3], got.idx);
				errors++;
				return;
			end
			want = due.pop_front();
			compare_field("out_x", want.pos[0], got.pos[0]);
			compare_field("out_y", want.pos[1], got.pos[1]);
			compare_field("out_z", want.pos[2], got.pos[2]);
			compare_field("out_w", want.pos[3], got.pos[3]);
			compare_field("sample_index", want.idx, got.idx);
			compare_field("segment_last", want.last, got.last);
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT and its ports
	// ------------------------------------------------------------------------
	logic   clk;
	logic   arst_n;
	logic   pt_valid;
	logic   pt_stall;
	coord_t coord_x, coord_y, coord_z, coord_w;
	logic   close_loop;
	logic   smp_valid;
	logic   smp_stall;
	coord_t out_x, out_y, out_z, out_w;
	logic [IDX_W-1:0] sample_index;
	logic   segment_last;

	cubic_bezier_loop_tessellator_unit #(
		.SAMPLES     (SEG_SAMPLES),
		.COORD_WIDTH (COORD_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pt_valid     (pt_valid),
		.pt_stall     (pt_stall),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.coord_w      (coord_w),
		.close_loop   (close_loop),
		.smp_valid    (smp_valid),
		.smp_stall    (smp_stall),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.out_w        (out_w),
		.sample_index (sample_index),
		.segment_last (segment_last)
	);

	bezier_scoreboard sb;
	int  points_sent;
	bit  calm;        // no idling on either side while set
	bit  hold_req;    // asks the sample sink for one long hold-off

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit. Slowest correct run: ~370 points, ~1300 samples, random
	// sample stalls plus the hold-off; the limit below leaves a wide margin.
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Sample side: stall driven at negedge, requests taken at posedge
	// ------------------------------------------------------------------------
	initial begin : sample_sink
		int hold_left;
		hold_left = 0;
		smp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				// long back-pressure: the segment queue fills, pt_stall rises
				smp_stall <= 1'b1;
				hold_left--;
			end else begin
				smp_stall <= !calm && ($urandom_range(0, 99) < 31);
			end
		end
	end

	always @(posedge clk) begin : sample_monitor
		curve_sample_t got;
		if (arst_n && smp_valid && !smp_stall) begin
			got.pos[0] = out_x;
			got.pos[1] = out_y;
			got.pos[2] = out_z;
			got.pos[3] = out_w;
			got.idx    = sample_index;
			got.last   = segment_last;
			sb.check_sample(got);
		end
	end

	// ------------------------------------------------------------------------
	// Point side
	// ------------------------------------------------------------------------

	// Offer one point request, with random idle cycles ahead of it, and hold
	// it until accepted. Valid stays high into the next call if no idle.
	task automatic send_point(input coord_t x, y, z, w, input logic close_flag);
		point_t p;
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 31) begin
			pt_valid <= 1'b0;
			@(negedge clk);
		end
		pt_valid   <= 1'b1;
		coord_x    <= x;
		coord_y    <= y;
		coord_z    <= z;
		coord_w    <= w;
		close_loop <= close_flag;
		do @(posedge clk); while (pt_stall);
		p = '{x, y, z, w};
		sb.note_point(p, close_flag);
		points_sent++;
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0:       return C_MAX;
			1:       return C_MIN;
			2:       return coord_t'($urandom_range(0, 255)) - coord_t'(128);
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic send_random(input logic close_flag);
		send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(), close_flag);
	endtask

	// Stop offering and let every pending sample come out
	task automatic drain_points();
		@(negedge clk);
		pt_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int goal;
		int loop_no;
		int nseg;
		sb          = new();
		points_sent = 0;
		calm        = 1'b0;
		hold_req    = 1'b0;
		arst_n      = 1'b1;
		pt_valid    = 1'b0;
		coord_x     = '0;
		coord_y     = '0;
		coord_z     = '0;
		coord_w     = '0;
		close_loop  = 1'b0;
		// clean falling edge so the async reset is seen before the first clock
		#1 arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed loop 1: close flag ignored on the start point, on the
		// first handle and on an endpoint; extreme coordinates
		send_point(C_MAX, C_MIN, C_ZERO, -16'sd1, 1'b1);
		send_point(C_MIN, C_MAX, 16'sd1, C_ZERO, 1'b1);
		send_point(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
		send_point(C_MIN, C_MIN, C_MIN, C_MIN, 1'b1);
		// rising to all-max, then a flat all-max segment (rounding may clip)
		send_point(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
		send_point(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
		send_point(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
		send_point(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
		send_point(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
		send_point(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
		// falling to all-min
		send_point(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0);
		send_point(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0);
		send_point(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0);
		// close back to the first endpoint
		send_point(16'sh5555, -16'sh2aab, 16'sh4000, -16'sh4000, 1'b0);
		send_point(-16'sh5556, 16'sh2aaa, C_ZERO, 16'sh1234, 1'b1);
		// Directed loop 2: closed right after its first segment's handles
		send_point(C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0);
		send_point(C_MAX, C_MIN, C_MAX, C_MIN, 1'b0);
		send_point(C_MIN, C_MAX, C_MIN, C_MAX, 1'b1);

		// Random loops, mostly well formed
		goal    = points_sent + RAND_POINTS;
		loop_no = 0;
		while (points_sent < goal) begin
			loop_no++;
			if (loop_no == 4)
				hold_req = 1'b1;
			if (loop_no == 9)
				drain_points();
			calm = (loop_no >= 14 && loop_no < 24);

			send_random($urandom_range(0, 4) == 0);
			nseg = $urandom_range(0, 5);
			repeat (nseg) begin
				send_random($urandom_range(0, 5) == 0);
				send_random(1'b0);
				send_random($urandom_range(0, 5) == 0);
			end
			if ($urandom_range(0, 99) < 85) begin
				send_random($urandom_range(0, 5) == 0);
				send_random(1'b1);
			end else begin
				// broken tail: loop left open, the next start lands mid-segment
				repeat ($urandom_range(0, 2))
					send_random($urandom_range(0, 1) == 1);
			end
		end
		calm = 1'b0;

		drain_points();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
